// ===== sv/array_doubly_linked_list_manager_top_assert.svh =====
// Assertion macros for the doubly linked list manager.
// Used by the top level; needs a clock and an active-low reset in scope.
`ifndef ARRAY_DOUBLY_LINKED_LIST_MANAGER_TOP_ASSERT_SVH
`define ARRAY_DOUBLY_LINKED_LIST_MANAGER_TOP_ASSERT_SVH
// Implication checked at every rising edge outside reset.
`define ADLL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ADLL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/adll_pkg.sv =====
// Types and codes shared by the doubly linked list manager.
// No dependencies.
package adll_pkg;
    localparam int KIND_W = 3;
    localparam int FIELD_W = 6;
    localparam int ST_W = 2;

    localparam logic [KIND_W-1:0] K_INS_AFTER = 3'd0;
    localparam logic [KIND_W-1:0] K_INS_BEFORE = 3'd1;
    localparam logic [KIND_W-1:0] K_REM_SLOT = 3'd2;
    localparam logic [KIND_W-1:0] K_INS_POS = 3'd3;
    localparam logic [KIND_W-1:0] K_REM_POS = 3'd4;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_UNUSED = 2'd3;

    // Request beat: operation, slot or position, and the value for a new node.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] target;
        logic signed [31:0] value;
    } t_req;

    // Result beat: status, slot touched, and the list ends and length afterwards.
    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [FIELD_W-1:0] slot_used;
        logic [FIELD_W-1:0] head_slot;
        logic [FIELD_W-1:0] tail_slot;
        logic [FIELD_W-1:0] node_count;
    } t_rsp;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,      // clearing pass over the link memory
        S_IDLE,
        S_RD_HEAD,   // sentinel links arrive
        S_WALK,      // one next link per cycle
        S_RD_TGT,    // target entry arrives
        S_RD_ANC,    // removed node's prev entry arrives (remove)
        S_RD_NB,     // free slot entry arrives
        S_WR1,
        S_WR2,
        S_WR3,
        S_DONE
    } t_state;
endpackage

// ===== sv/adll_if.sv =====
// Valid/ready channel carrying one beat of payload.
// Payload type is a parameter; no package dependency.
interface adll_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/adll_mem.sv =====
// Synchronous link and value store: one write and one read port per cycle.
// Depends on nothing; read data are registered and appear in the cycle after the address.
module adll_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/array_doubly_linked_list_manager_top.sv =====
// Doubly linked list manager over a synchronous slot store.
// A request refused at once answers from idle; a slot not in use or a full store ends
// the operation before any link is written. A position operation first walks up to 63
// links from the head, one at a time through the single read port of the link memory.
// One item is in flight; the next request is taken no earlier than the cycle its
// predecessor's result beat leaves. After reset a clearing pass over every slot builds
// the free chain; no item is taken meanwhile.
`include "array_doubly_linked_list_manager_top_assert.svh"
module array_doubly_linked_list_manager_top
    import adll_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    adll_if.sink   i_req,
    adll_if.source o_rsp
);
    localparam int AW = $clog2(SLOTS);
    localparam int LW = AW + 1;           // link holds SLOTS as end of free chain
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = 2 * LW + 1;       // next, prev, in-use

    typedef struct packed {
        logic         used;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } t_ent;

    t_state r_state, n_state;
    logic [AW-1:0] r_init, n_init;
    logic [2:0]    r_kind, n_kind;
    logic [5:0]    r_tgt, n_tgt;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [AW-1:0] r_cur, n_cur;          // walk position, new node or node being removed
    logic [AW-1:0] r_anc, n_anc;          // insert anchor
    logic [AW-1:0] r_nb, n_nb;            // neighbour (anchor's next or removed prev)
    logic [AW-1:0] r_nb2, n_nb2;          // removed node's next
    logic [5:0]    r_steps, n_steps;
    logic [LW-1:0] r_free, n_free;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_ovld;
    logic [ST_W-1:0] r_ost;
    logic [5:0]    r_oslot;
    logic          fin;
    logic [ST_W-1:0] fin_st;
    logic [AW-1:0] fin_slot;
    logic          ins_op;
    logic          free_empty;

    // Memory ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_ent          wdat, rd;
    logic [MW-1:0] rd_raw;
    logic          vwe;
    logic [VALUE_BITS-1:0] vrd;
    logic          unused_v;

    function automatic logic [AW-1:0] lnk(input logic [LW-1:0] v);
        return v[LW-1] ? AW'(0) : v[AW-1:0];
    endfunction

    adll_mem #(.DEPTH(SLOTS), .WIDTH(MW)) u_links (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdat),
        .i_raddr(raddr), .o_rdata(rd_raw)
    );
    assign rd = t_ent'(rd_raw);

    // Value store; never read back, so its read port is tied to the write slot.
    adll_mem #(.DEPTH(SLOTS), .WIDTH(VALUE_BITS)) u_vals (
        .i_clk(i_clk), .i_we(vwe), .i_waddr(r_cur), .i_wdata(r_val),
        .i_raddr(r_cur), .o_rdata(vrd)
    );
    assign unused_v = ^vrd;

    assign ins_op = (r_kind == K_INS_AFTER) || (r_kind == K_INS_BEFORE)
                 || (r_kind == K_INS_POS);
    assign free_empty = (r_free >= LW'(SLOTS));
    assign i_req.ready = (r_state == S_IDLE) && !(r_ovld && !o_rsp.ready);

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_init = r_init; n_kind = r_kind; n_tgt = r_tgt; n_val = r_val;
        n_cur = r_cur; n_anc = r_anc; n_nb = r_nb; n_nb2 = r_nb2;
        n_steps = r_steps; n_free = r_free; n_count = r_count;
        n_head = r_head; n_tail = r_tail;
        we = 1'b0; waddr = '0; wdat = '0; raddr = '0; vwe = 1'b0;
        fin = 1'b0; fin_st = ST_BAD; fin_slot = '0;
        case (r_state)
            S_INIT: begin
                we = 1'b1; waddr = r_init;
                wdat.used = (r_init == '0);
                wdat.prv = '0;
                wdat.nxt = (r_init == '0) ? '0 : LW'(r_init) + LW'(1);
                n_init = r_init + AW'(1);
                if (r_init == AW'(SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_kind = i_req.data.kind;
                    n_tgt = i_req.data.target;
                    n_val = VALUE_BITS'(i_req.data.value);
                    case (i_req.data.kind)
                        K_INS_AFTER, K_INS_BEFORE, K_REM_SLOT: begin
                            if ({26'd0, i_req.data.target} >= 32'(SLOTS)) begin
                                fin = 1'b1;
                            end else if (i_req.data.kind == K_REM_SLOT
                                         && i_req.data.target == 6'd0) begin
                                fin = 1'b1;
                            end else begin
                                raddr = AW'(i_req.data.target);
                                n_state = S_RD_TGT;
                            end
                        end
                        K_INS_POS, K_REM_POS: begin
                            n_cur = r_head;
                            n_steps = (i_req.data.kind == K_INS_POS
                                       && i_req.data.target != 6'd0)
                                    ? i_req.data.target - 6'd1 : i_req.data.target;
                            raddr = r_head;
                            n_state = S_WALK;
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            S_WALK: begin
                // rd holds the entry of r_cur
                if (r_steps == '0) begin
                    if (r_kind == K_INS_POS) begin
                        n_anc = r_cur;
                        if (free_empty) begin
                            fin = 1'b1; fin_st = ST_FULL; n_state = S_IDLE;
                        end else begin
                            n_nb = lnk(rd.nxt);
                            raddr = r_free[AW-1:0];
                            n_state = S_RD_NB;
                        end
                    end else if (r_cur == '0) begin
                        fin = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_nb = lnk(rd.prv); n_nb2 = lnk(rd.nxt);
                        n_state = S_WR1;
                    end
                end else begin
                    n_cur = lnk(rd.nxt);
                    raddr = lnk(rd.nxt);
                    n_steps = r_steps - 6'd1;
                end
            end
            S_RD_TGT: begin
                n_cur = AW'(r_tgt);
                if (!rd.used) begin
                    fin = 1'b1; fin_st = ST_UNUSED; n_state = S_IDLE;
                end else if (r_kind == K_REM_SLOT) begin
                    n_nb = lnk(rd.prv); n_nb2 = lnk(rd.nxt);
                    n_state = S_WR1;
                end else if (free_empty) begin
                    fin = 1'b1; fin_st = ST_FULL; n_state = S_IDLE;
                end else if (r_kind == K_INS_AFTER) begin
                    n_anc = AW'(r_tgt); n_nb = lnk(rd.nxt);
                    raddr = r_free[AW-1:0];
                    n_state = S_RD_NB;
                end else begin
                    // insert before: anchor is the target's prev, new next is target
                    n_anc = lnk(rd.prv); n_nb = AW'(r_tgt);
                    raddr = r_free[AW-1:0];
                    n_state = S_RD_NB;
                end
            end
            S_RD_NB: begin
                // rd holds the free slot; pop it and link it in
                n_cur = r_free[AW-1:0];
                n_free = (rd.nxt > LW'(SLOTS)) ? LW'(SLOTS) : rd.nxt;
                we = 1'b1; waddr = r_free[AW-1:0];
                wdat.used = 1'b1; wdat.nxt = LW'(r_nb); wdat.prv = LW'(r_anc);
                raddr = r_anc;
                n_state = S_WR1;
            end
            S_WR1: begin
                if (ins_op) begin
                    // rd holds the anchor; point its next at the new node
                    we = 1'b1; waddr = r_anc;
                    wdat = rd; wdat.nxt = LW'(r_cur);
                    raddr = r_nb;
                    n_state = S_WR2;
                end else begin
                    // removed node back on the free chain
                    we = 1'b1; waddr = r_cur;
                    wdat.used = 1'b0; wdat.nxt = r_free; wdat.prv = '0;
                    n_free = LW'(r_cur);
                    raddr = r_nb;
                    n_state = S_RD_ANC;
                end
            end
            S_RD_ANC: begin
                // rd holds the removed node's prev
                we = 1'b1; waddr = r_nb;
                wdat = rd; wdat.nxt = LW'(r_nb2);
                raddr = r_nb2;
                n_state = S_WR2;
            end
            S_WR2: begin
                we = 1'b1;
                if (ins_op) begin
                    waddr = r_nb; wdat = rd;
                    // anchor equal to neighbour: next was just written this way too
                    if (r_nb == r_anc) wdat.nxt = LW'(r_cur);
                    wdat.prv = LW'(r_cur);
                end else begin
                    waddr = r_nb2; wdat = rd;
                    if (r_nb2 == r_nb) wdat.nxt = LW'(r_nb2);
                    wdat.prv = LW'(r_nb);
                end
                n_state = S_WR3;
            end
            S_WR3: begin
                // refresh head and tail copies, store an inserted node's value and finish
                if (ins_op) begin
                    vwe = 1'b1;
                    if (r_anc == '0) n_head = r_cur;
                    if (r_nb == '0) n_tail = r_cur;
                    n_count = r_count + CW'(1);
                end else begin
                    if (r_nb == '0) n_head = r_nb2;
                    if (r_nb2 == '0) n_tail = r_nb;
                    n_count = r_count - CW'(1);
                end
                fin = 1'b1; fin_st = ST_OK; fin_slot = r_cur;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init <= '0;
            r_free <= LW'(1);
            r_count <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init <= n_init;
            r_free <= n_free;
            r_count <= n_count;
            r_head <= n_head;
            r_tail <= n_tail;
            if (fin) r_ovld <= 1'b1;
            else if (o_rsp.ready) r_ovld <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_tgt <= n_tgt; r_val <= n_val;
        r_cur <= n_cur; r_anc <= n_anc; r_nb <= n_nb; r_nb2 <= n_nb2;
        r_steps <= n_steps;
        if (fin) begin
            r_ost <= fin_st;
            r_oslot <= (fin_st == ST_OK) ? 6'(fin_slot) : 6'd0;
        end
    end

    assign o_rsp.valid = r_ovld;
    assign o_rsp.data.status = r_ost;
    assign o_rsp.data.slot_used = r_oslot;
    assign o_rsp.data.head_slot = 6'(r_head);
    assign o_rsp.data.tail_slot = 6'(r_tail);
    assign o_rsp.data.node_count = 6'(r_count);

    `ADLL_ASSERT_IMP(a_ready_idle, i_req.ready, r_state == S_IDLE, "ready outside idle")
    `ADLL_ASSERT_NXT(a_ok_result, fin && fin_st == ST_OK, r_ovld && r_oslot != 6'd0,
                     "ok result without slot")
    `ADLL_ASSERT_IMP(a_count_range, r_state == S_IDLE, r_count < CW'(SLOTS),
                     "count beyond store")
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for array_doubly_linked_list_manager_top.
// Depends on adll_pkg and adll_if; holds its own model of the slot store and
// checks every result beat against it.
module tb;
    import adll_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = 64;
    localparam int HALF_PERIOD = 6;

    logic i_clk;
    logic i_rst_n;
    bit no_idle;
    int err_count;
    int ops_sent;
    int results_seen;

    adll_if #(.T(t_req)) req_ch ();
    adll_if #(.T(t_rsp)) rsp_ch ();

    array_doubly_linked_list_manager_top #(.SLOTS(NSLOTS), .VALUE_BITS(32)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Shadow copy of the link store.
    logic [6:0] next_of [NSLOTS];
    logic [5:0] prev_of [NSLOTS];
    bit slot_live [NSLOTS];
    int first_spare;
    int list_len;
    t_rsp expected_rsp [$];

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_rsp.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void reset_shadow();
        for (int i = 0; i < NSLOTS; i++) begin
            next_of[i] = 7'(i + 1);
            prev_of[i] = '0;
            slot_live[i] = 1'b0;
        end
        next_of[0] = '0;
        slot_live[0] = 1'b1;
        first_spare = 1;
        list_len = 0;
    endfunction

    function automatic int link_next(int i);
        return (next_of[i] < NSLOTS) ? int'(next_of[i]) : 0;
    endfunction

    function automatic logic [ST_W-1:0] link_after(int anchor, output int slot);
        int n;
        int nx;
        slot = 0;
        if (!slot_live[anchor]) return ST_UNUSED;
        if (first_spare >= NSLOTS) return ST_FULL;
        n = first_spare;
        first_spare = (next_of[n] <= NSLOTS) ? int'(next_of[n]) : NSLOTS;
        nx = link_next(anchor);
        next_of[n] = 7'(nx);
        prev_of[n] = 6'(anchor);
        next_of[anchor] = 7'(n);
        prev_of[nx] = 6'(n);
        slot_live[n] = 1'b1;
        list_len++;
        slot = n;
        return ST_OK;
    endfunction

    function automatic logic [ST_W-1:0] unlink_slot(int r, output int slot);
        int p;
        int nx;
        slot = 0;
        if (r == 0 || r >= NSLOTS) return ST_BAD;
        if (!slot_live[r]) return ST_UNUSED;
        p = prev_of[r];
        nx = link_next(r);
        next_of[p] = 7'(nx);
        prev_of[nx] = 6'(p);
        next_of[r] = 7'(first_spare);
        prev_of[r] = '0;
        slot_live[r] = 1'b0;
        first_spare = r;
        list_len--;
        slot = r;
        return ST_OK;
    endfunction

    function automatic int walk_from_head(int steps);
        int cur;
        cur = link_next(0);
        for (int i = 0; i < steps; i++) cur = link_next(cur);
        return cur;
    endfunction

    // Applies one operation to the shadow store and returns the result it gives.
    function automatic t_rsp predict_list_op(t_req r);
        t_rsp res;
        int slot;
        int tgt;
        logic [ST_W-1:0] st;
        tgt = r.target;
        st = ST_BAD;
        slot = 0;
        case (r.kind)
            K_INS_AFTER: st = link_after(tgt, slot);
            K_INS_BEFORE: begin
                if (!slot_live[tgt]) st = ST_UNUSED;
                else st = link_after(prev_of[tgt], slot);
            end
            K_REM_SLOT: st = unlink_slot(tgt, slot);
            K_INS_POS: st = link_after(walk_from_head(tgt > 0 ? tgt - 1 : 0), slot);
            K_REM_POS: st = unlink_slot(walk_from_head(tgt), slot);
            default: st = ST_BAD;
        endcase
        if (st != ST_OK) slot = 0;
        res.status = st;
        res.slot_used = 6'(slot);
        res.head_slot = 6'(link_next(0));
        res.tail_slot = prev_of[0];
        res.node_count = 6'(list_len);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("Mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // Sends one request beat and records the result it should produce.
    task automatic send_list_op(logic [KIND_W-1:0] kind, int target, logic [31:0] value);
        t_req r;
        r.kind = kind;
        r.target = 6'(target);
        r.value = value;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 29) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_rsp.push_back(predict_list_op(r));
        ops_sent++;
    endtask

    // Result side stalls at random on each falling edge unless no_idle is set, and holds off in reset.
    always @(negedge i_clk) begin
        rsp_ch.ready <= i_rst_n && (no_idle || ($urandom_range(0, 99) >= 29));
    end

    // Each accepted result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            results_seen++;
            if (expected_rsp.size() == 0) begin
                report_mismatch("beats outstanding", 1, 0);
            end else begin
                want = expected_rsp.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.slot_used !== want.slot_used)
                    report_mismatch("slot_used", got.slot_used, want.slot_used);
                if (got.head_slot !== want.head_slot)
                    report_mismatch("head_slot", got.head_slot, want.head_slot);
                if (got.tail_slot !== want.tail_slot)
                    report_mismatch("tail_slot", got.tail_slot, want.tail_slot);
                if (got.node_count !== want.node_count)
                    report_mismatch("node_count", got.node_count, want.node_count);
            end
        end
    end

    // Returns a random slot in use, the sentinel included.
    function automatic int pick_live_slot();
        int s;
        s = $urandom_range(0, NSLOTS - 1);
        while (!slot_live[s]) s = (s + 1) % NSLOTS;
        return s;
    endfunction

    // Empty list errors, both ends, unknown kinds and value extremes.
    task automatic test_edge_cases();
        send_list_op(K_REM_SLOT, 0, '0);
        send_list_op(K_REM_SLOT, 5, '0);
        send_list_op(K_REM_POS, 0, '0);
        send_list_op(K_INS_AFTER, 7, 32'h1234_5678);
        send_list_op(K_INS_BEFORE, 63, '0);
        send_list_op(K_INS_AFTER, 0, 32'h8000_0000);
        send_list_op(K_INS_BEFORE, 0, 32'h7FFF_FFFF);
        send_list_op(K_INS_BEFORE, 2, 32'hFFFF_FFFF);
        send_list_op(K_INS_AFTER, 1, '0);
        send_list_op(K_INS_POS, 0, 32'h5555_5555);
        send_list_op(K_INS_POS, 1, 32'hAAAA_AAAA);
        send_list_op(K_INS_POS, 63, 32'h0000_0001);
        send_list_op(K_REM_POS, 63, '0);
        send_list_op(K_REM_POS, 2, '0);
        send_list_op(K_REM_SLOT, 3, '0);
        send_list_op(K_REM_SLOT, 3, '0);
        send_list_op(3'd5, 1, '0);
        send_list_op(3'd6, 42, '0);
        send_list_op(3'd7, 21, '0);
        send_list_op(K_REM_SLOT, 63, '0);
    endtask

    // Fill the store to overflow, then drain it from the head.
    task automatic test_full_store();
        while (list_len < NSLOTS - 1)
            send_list_op(K_INS_POS, $urandom_range(0, 63), $urandom);
        send_list_op(K_INS_AFTER, pick_live_slot(), $urandom);
        send_list_op(K_INS_BEFORE, 0, $urandom);
        send_list_op(K_INS_AFTER, 63, $urandom);
        while (list_len > 0) send_list_op(K_REM_POS, 0, '0);
        send_list_op(K_REM_POS, 0, '0);
    endtask

    // Mostly well-formed operations on live slots, with some noise.
    task automatic test_random_ops(int n_ops);
        int roll;
        int pos;
        logic [KIND_W-1:0] kind;
        for (int i = 0; i < n_ops; i++) begin
            no_idle = (i >= n_ops / 3) && (i < n_ops / 2);
            roll = $urandom_range(0, 99);
            pos = $urandom_range(0, list_len + 2);
            if (roll < 10) begin
                send_list_op(3'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom);
            end else if (roll < 55 - (list_len > 40 ? 20 : 0)) begin
                kind = (roll % 3 == 0) ? K_INS_POS : (roll % 3 == 1) ? K_INS_AFTER
                                                                      : K_INS_BEFORE;
                send_list_op(kind, kind == K_INS_POS ? pos : pick_live_slot(), $urandom);
            end else if (roll % 2 == 0) begin
                send_list_op(K_REM_POS, pos, $urandom);
            end else begin
                send_list_op(K_REM_SLOT, pick_live_slot(), $urandom);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        err_count = 0;
        ops_sent = 0;
        results_seen = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        reset_shadow();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_full_store();
        test_random_ops(350);

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d list operations and checked %0d results,", ops_sent,
                 results_seen);
        $display("covering empty and full store, wrapping walks and bad requests.");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
